// ===== hw/rtl/active_fault_code_list_unit_defines.svh =====
// ----------------------------------------------------------------------------
// active_fault_code_list_unit_defines.svh
// Assertion macros shared by the fault list RTL.
// ----------------------------------------------------------------------------
`ifndef ACTIVE_FAULT_CODE_LIST_UNIT_DEFINES_SVH
`define ACTIVE_FAULT_CODE_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACFL_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fault list: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ACFL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fault list: next-cycle check failed");

`endif

// ===== hw/rtl/acfl_pkg.sv =====
// ----------------------------------------------------------------------------
// acfl_pkg
// Types, operation codes and helpers for the active fault code list.
// ----------------------------------------------------------------------------
package acfl_pkg;

  localparam int CODE_W           = 10;
  localparam int BYTE_W           = 8;
  localparam int NUM_ENTRY_FIELDS = 5;
  localparam int MAP_BYTES_DEF    = 64;
  localparam int LIST_DEPTH_DEF   = 5;

  localparam logic [1:0] OP_RAISE  = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;
  localparam logic [1:0] OP_DECODE = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CODE_W-1:0] fault_code;
    logic              reset_level;
  } in_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0] entry0;
    logic [CODE_W-1:0] entry1;
    logic [CODE_W-1:0] entry2;
    logic [CODE_W-1:0] entry3;
    logic [CODE_W-1:0] entry4;
    logic              any_active;
  } out_beat_t;

  // Commands from the sequencer to the code list.
  typedef struct packed {
    logic              clear_all;
    logic              shift;
    logic              insert;
    logic [CODE_W-1:0] code;
  } list_ctl_t;

  // Position of the lowest set bit; zero for an empty byte.
  function automatic logic [2:0] lsb_index(input logic [BYTE_W-1:0] b);
    logic [2:0] idx;
    idx = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (b[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/acfl_map_mem.sv =====
// ----------------------------------------------------------------------------
// acfl_map_mem
// Fault map byte memory, one read and one write port, registered read.
// ----------------------------------------------------------------------------
module acfl_map_mem #(
  parameter int MAP_BYTES = acfl_pkg::MAP_BYTES_DEF,
  parameter int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [acfl_pkg::BYTE_W-1:0] rd_byte,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [acfl_pkg::BYTE_W-1:0] wr_byte
);

  logic [acfl_pkg::BYTE_W-1:0] mem [MAP_BYTES];
  logic [MAP_BYTES-1:0]        vld_r;
  logic [acfl_pkg::BYTE_W-1:0] rd_data_r;
  logic                        rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_byte = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== hw/rtl/acfl_code_list.sv =====
// ----------------------------------------------------------------------------
// acfl_code_list
// Ordered list of fault codes: append, shift up, clear.
// ----------------------------------------------------------------------------
module acfl_code_list #(
  parameter int LIST_DEPTH = acfl_pkg::LIST_DEPTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  acfl_pkg::list_ctl_t                        ctl,
  output logic [LIST_DEPTH-1:0][acfl_pkg::CODE_W-1:0] list_o
);

  logic [acfl_pkg::CODE_W-1:0] list_r   [LIST_DEPTH];
  logic [acfl_pkg::CODE_W-1:0] list_nxt [LIST_DEPTH];
  logic                        placed;

  always_comb begin
    placed = 1'b0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      list_nxt[k] = list_r[k];
    end
    if (ctl.clear_all) begin
      for (int k = 0; k < LIST_DEPTH; k++) begin
        list_nxt[k] = '0;
      end
    end else if (ctl.shift) begin
      for (int k = 0; k < LIST_DEPTH - 1; k++) begin
        list_nxt[k] = list_r[k+1];
      end
      list_nxt[LIST_DEPTH-1] = '0;
    end else if (ctl.insert) begin
      // stop at the first slot that is empty or already holds the code
      for (int k = 0; k < LIST_DEPTH; k++) begin
        if (!placed) begin
          if (list_r[k] == '0) begin
            list_nxt[k] = ctl.code;
            placed      = 1'b1;
          end else if (list_r[k] == ctl.code) begin
            placed = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LIST_DEPTH; k++) begin
        list_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < LIST_DEPTH; k++) begin
        list_r[k] <= list_nxt[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < LIST_DEPTH; k++) begin
      list_o[k] = list_r[k];
    end
  end

endmodule

// ===== hw/rtl/active_fault_code_list_unit.sv =====
// Raise, clear and reset-sample: accepted, then a read-modify-write state, result strobe
// in the next cycle; a new start is taken in the strobe cycle.
// Decode: steps through the map a byte at a time, plus a step per extra code found in a
// byte, until the list is full or the last byte is done; its pace is set by the single map read port.
// Decode with no active fault answers without a scan. Reset clears map valid bits, list,
// counters and sequencer at once; results are never held off by the receiver.
// ----------------------------------------------------------------------------
// active_fault_code_list_unit
// Active-fault bit map in a byte memory plus a short ordered list of fault codes.
// ----------------------------------------------------------------------------
`include "active_fault_code_list_unit_defines.svh"

module active_fault_code_list_unit #(
  parameter int MAP_BYTES  = acfl_pkg::MAP_BYTES_DEF,
  parameter int LIST_DEPTH = acfl_pkg::LIST_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  acfl_pkg::in_beat_t  in_payload,
  output logic                out_valid,
  output acfl_pkg::out_beat_t out_payload
);

  localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int NZ_W   = $clog2(MAP_BYTES + 1);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int CODE_W = acfl_pkg::CODE_W;
  localparam int BYTE_W = acfl_pkg::BYTE_W;
  localparam logic [CODE_W:0] MAX_CODE = (CODE_W+1)'(MAP_BYTES * 8);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RMW  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  // Code lies in 1 .. MAP_BYTES*8.
  function automatic logic code_ok(input logic [CODE_W-1:0] c);
    return (c != '0) && ({1'b0, c} <= MAX_CODE);
  endfunction

  // Byte holding a code's map bit.
  function automatic logic [ADDR_W-1:0] code_addr(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] c1;
    logic [CODE_W-4:0] b;
    c1 = c - CODE_W'(1);
    b  = c1[CODE_W-1:3];
    return b[ADDR_W-1:0];
  endfunction

  // Sequencer state.
  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              take_rd_r, take_rd_nxt;
  logic [CNT_W-1:0]  found_r, found_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              do_wr_r, do_wr_nxt;
  logic              set_r, set_nxt;
  logic              shift_r, shift_nxt;
  logic              lvl_r, lvl_nxt;
  logic [NZ_W-1:0]   nz_r, nz_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Memory and list hookup.
  logic                              rd_en;
  logic [ADDR_W-1:0]                 rd_addr;
  logic [BYTE_W-1:0]                 rd_byte;
  logic                              wr_en;
  logic [BYTE_W-1:0]                 new_byte;
  logic [BYTE_W-1:0]                 bit_mask;
  logic [CODE_W-1:0]                 code_m1;
  acfl_pkg::list_ctl_t               list_ctl;
  logic [LIST_DEPTH-1:0][CODE_W-1:0] list_q;
  logic [CODE_W-1:0]                 head;
  logic                              accept;
  logic                              rise_seen;

  // Scan datapath.
  logic [BYTE_W-1:0] cur_byte;
  logic [BYTE_W-1:0] left_byte;
  logic              has_bit;
  logic [2:0]        bit_pos;
  logic [CODE_W-1:0] found_code;
  logic              list_full;
  logic              last_byte;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign head   = list_q[0];
  assign rise_seen = !lvl_r && in_payload.reset_level && (head != '0);

  // Read-modify-write of one map byte: set or drop the addressed bit.
  assign code_m1  = code_r - CODE_W'(1);
  assign bit_mask = BYTE_W'(1) << code_m1[2:0];
  assign new_byte = set_r ? (rd_byte | bit_mask) : (rd_byte & ~bit_mask);

  // Current byte under scan: fresh from memory or what is left of the held one.
  assign cur_byte   = take_rd_r ? rd_byte : byte_r;
  assign has_bit    = (cur_byte != '0);
  assign bit_pos    = acfl_pkg::lsb_index(cur_byte);
  assign left_byte  = cur_byte & (cur_byte - BYTE_W'(1));
  assign found_code = CODE_W'({addr_r, bit_pos}) + CODE_W'(1);
  assign list_full  = has_bit && (found_r == CNT_W'(LIST_DEPTH - 1));
  assign last_byte  = (addr_r == ADDR_W'(MAP_BYTES - 1));

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    byte_nxt      = byte_r;
    take_rd_nxt   = take_rd_r;
    found_nxt     = found_r;
    code_nxt      = code_r;
    do_wr_nxt     = do_wr_r;
    set_nxt       = set_r;
    shift_nxt     = shift_r;
    lvl_nxt       = lvl_r;
    nz_nxt        = nz_r;
    out_valid_nxt = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = addr_r;
    wr_en         = 1'b0;
    list_ctl      = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_payload.operation)
            acfl_pkg::OP_RAISE, acfl_pkg::OP_CLEAR: begin
              // fetch the byte; out-of-range codes pass through untouched
              code_nxt  = in_payload.fault_code;
              do_wr_nxt = code_ok(in_payload.fault_code);
              set_nxt   = (in_payload.operation == acfl_pkg::OP_RAISE);
              shift_nxt = 1'b0;
              addr_nxt  = code_addr(in_payload.fault_code);
              rd_en     = 1'b1;
              rd_addr   = code_addr(in_payload.fault_code);
              state_nxt = ST_RMW;
            end
            acfl_pkg::OP_SAMPLE: begin
              // rising reset command with a listed head: drop the head's bit, shift up
              code_nxt  = head;
              do_wr_nxt = rise_seen && code_ok(head);
              set_nxt   = 1'b0;
              shift_nxt = rise_seen;
              lvl_nxt   = in_payload.reset_level;
              addr_nxt  = code_addr(head);
              rd_en     = 1'b1;
              rd_addr   = code_addr(head);
              state_nxt = ST_RMW;
            end
            default: begin
              if (nz_r == '0) begin
                // nothing active: empty the list and answer at once
                list_ctl.clear_all = 1'b1;
                out_valid_nxt      = 1'b1;
              end else begin
                found_nxt   = '0;
                addr_nxt    = '0;
                take_rd_nxt = 1'b1;
                rd_en       = 1'b1;
                rd_addr     = '0;
                state_nxt   = ST_SCAN;
              end
            end
          endcase
        end
      end

      ST_RMW: begin
        wr_en = do_wr_r;
        if (do_wr_r) begin
          if ((rd_byte == '0) && (new_byte != '0)) begin
            nz_nxt = nz_r + NZ_W'(1);
          end else if ((rd_byte != '0) && (new_byte == '0)) begin
            nz_nxt = nz_r - NZ_W'(1);
          end
        end
        list_ctl.shift = shift_r;
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_IDLE;
      end

      ST_SCAN: begin
        // take the lowest active code of this byte and append it
        list_ctl.insert = has_bit;
        list_ctl.code   = found_code;
        if (has_bit) begin
          found_nxt = found_r + CNT_W'(1);
        end
        if (list_full) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (left_byte == '0) begin
          if (last_byte) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            // advance to the next byte, data lands next cycle
            addr_nxt    = addr_r + ADDR_W'(1);
            rd_en       = 1'b1;
            rd_addr     = addr_r + ADDR_W'(1);
            take_rd_nxt = 1'b1;
          end
        end else begin
          // hold the remaining bits of this byte
          byte_nxt    = left_byte;
          take_rd_nxt = 1'b0;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      take_rd_r   <= 1'b0;
      found_r     <= '0;
      do_wr_r     <= 1'b0;
      shift_r     <= 1'b0;
      lvl_r       <= 1'b0;
      nz_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      take_rd_r   <= take_rd_nxt;
      found_r     <= found_nxt;
      do_wr_r     <= do_wr_nxt;
      shift_r     <= shift_nxt;
      lvl_r       <= lvl_nxt;
      nz_r        <= nz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload holding registers.
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    byte_r <= byte_nxt;
    code_r <= code_nxt;
    set_r  <= set_nxt;
  end

  // The busy interlock keeps the next read behind this write, so no forwarding.
  acfl_map_mem #(
    .MAP_BYTES (MAP_BYTES),
    .ADDR_W    (ADDR_W)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_byte (rd_byte),
    .wr_en   (wr_en),
    .wr_addr (addr_r),
    .wr_byte (new_byte)
  );

  acfl_code_list #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_list (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (list_ctl),
    .list_o (list_q)
  );

  // Result beat: list slots beyond the depth read zero.
  logic [CODE_W-1:0] ent [acfl_pkg::NUM_ENTRY_FIELDS];

  for (genvar g = 0; g < acfl_pkg::NUM_ENTRY_FIELDS; g++) begin : g_ent
    if (g < LIST_DEPTH) begin : g_used
      assign ent[g] = list_q[g];
    end else begin : g_unused
      assign ent[g] = '0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_payload.entry0     = ent[0];
  assign out_payload.entry1     = ent[1];
  assign out_payload.entry2     = ent[2];
  assign out_payload.entry3     = ent[3];
  assign out_payload.entry4     = ent[4];
  assign out_payload.any_active = (nz_r != '0);

  `ACFL_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE)
  `ACFL_ASSERT_NEXT(a_rmw_one, clk, rst_n, state_r == ST_RMW, (state_r == ST_IDLE) && out_valid_r)
  `ACFL_ASSERT_NEXT(a_accept_moves, clk, rst_n, accept, busy || out_valid_r)
  `ACFL_ASSERT_NOW(a_found_bound, clk, rst_n, state_r == ST_SCAN, found_r < CNT_W'(LIST_DEPTH))
  `ACFL_ASSERT_NOW(a_nz_bound, clk, rst_n, 1'b1, nz_r <= NZ_W'(MAP_BYTES))

endmodule
